FILE: rtl/fdr_pkg.sv
package fdr_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = COL_W + ROW_W;
  localparam int PIX_W      = 24;
  localparam int SIZE_W     = 9;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // One pixel retiring from the compare stage
  typedef struct packed {
    logic              go;
    logic              diff;
    logic              last;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic [SIZE_W-1:0] w;
    logic [SIZE_W-1:0] h;
  } box_upd_t;

  // Frame result
  typedef struct packed {
    logic              changed;
    logic              full_frame;
    logic [COL_W-1:0]  rect_x;
    logic [ROW_W-1:0]  rect_y;
    logic [SIZE_W-1:0] rect_width;
    logic [SIZE_W-1:0] rect_height;
  } box_res_t;

  // Saturate a size register to 1..maxv
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] maxv);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end
    return r;
  endfunction

endpackage

FILE: rtl/frame_dirty_rectangle.sv
// Dirty-rectangle tracker. Pixels of each frame arrive in raster order, one per
// transfer, and are compared against the previous frame held in an internal
// 65536 x 24 frame store, which is then overwritten. After the last pixel of a
// frame one result is given: the bounding box of changed pixels, a no-change
// result (all zero), or the whole frame when no previous frame exists or the
// frame size changed. The block sustains one pixel per clock while not stalled;
// that rate is set by the single read and single write of the frame store per
// pixel, with a bypass for a read of the entry being written. The result is
// registered at frame end. The store needs no clearing after reset.
// Write frame_width and frame_height (1..256, saturated) between frames only.
module frame_dirty_rectangle
  import fdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PIX_W-1:0]  in_pixel_rgb,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_changed,
  output logic              out_full_frame,
  output logic [COL_W-1:0]  out_rect_x,
  output logic [ROW_W-1:0]  out_rect_y,
  output logic [SIZE_W-1:0] out_rect_width,
  output logic [SIZE_W-1:0] out_rect_height
);

  logic [SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [SIZE_W-1:0] w_eff, h_eff;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              col_end, row_end, in_acc;
  logic              p_valid_r, p_last_r, p_go;
  logic [PIX_W-1:0]  p_pix_r;
  logic [COL_W-1:0]  p_x_r;
  logic [ROW_W-1:0]  p_y_r;
  logic [SIZE_W-1:0] p_w_r, p_h_r;
  logic [PIX_W-1:0]  old_pix;
  logic              out_valid_r;
  box_res_t          out_res_r, res;
  box_upd_t          upd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= SIZE_W'(MAX_WIDTH);
      frame_height_r <= SIZE_W'(MAX_HEIGHT);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign w_eff = clamp_size(frame_width_r, SIZE_W'(MAX_WIDTH));
  assign h_eff = clamp_size(frame_height_r, SIZE_W'(MAX_HEIGHT));

  // Hold the compare stage when its frame result cannot be placed
  assign p_go     = !(p_last_r && out_valid_r && out_stall);
  assign in_stall = p_valid_r && !p_go;
  assign in_acc   = in_valid && !in_stall;

  assign col_end = ({1'b0, col_r} + 1'b1) >= w_eff;
  assign row_end = ({1'b0, row_r} + 1'b1) >= h_eff;

  // Raster position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
  end

  // Compare stage: pixel is registered alongside the registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_acc) begin
      p_valid_r <= 1'b1;
    end else if (p_go) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_pix_r  <= in_pixel_rgb;
      p_x_r    <= col_r;
      p_y_r    <= row_r;
      p_last_r <= col_end && row_end;
      p_w_r    <= w_eff;
      p_h_r    <= h_eff;
    end
  end

  fdr_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr ({row_r, col_r}),
    .wr_en   (p_valid_r && p_go),
    .wr_addr ({p_y_r, p_x_r}),
    .wr_data (p_pix_r),
    .rd_data (old_pix)
  );

  always_comb begin
    upd.go   = p_valid_r && p_go;
    upd.diff = old_pix != p_pix_r;
    upd.last = p_last_r;
    upd.x    = p_x_r;
    upd.y    = p_y_r;
    upd.w    = p_w_r;
    upd.h    = p_h_r;
  end

  fdr_box u_box (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (upd),
    .res   (res)
  );

  // Output register: load at frame end, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (upd.go && p_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd.go && p_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_changed     = out_res_r.changed;
  assign out_full_frame  = out_res_r.full_frame;
  assign out_rect_x      = out_res_r.rect_x;
  assign out_rect_y      = out_res_r.rect_y;
  assign out_rect_width  = out_res_r.rect_width;
  assign out_rect_height = out_res_r.rect_height;

`ifndef ASSERT_OFF
  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(p_valid_r && p_last_r && p_go))
    else $error("result without a frame end");

  a_unchanged_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.changed) |->
      !out_res_r.full_frame && (out_res_r.rect_width == '0) && (out_res_r.rect_height == '0))
    else $error("no-change result carries a rectangle");

  a_full_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.full_frame) |->
      out_res_r.changed && (out_res_r.rect_x == '0) && (out_res_r.rect_y == '0))
    else $error("full frame result not at origin");
`endif

endmodule

FILE: rtl/fdr_store.sv
module fdr_store
  import fdr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [PIX_W-1:0]  wr_data,
  output logic [PIX_W-1:0]  rd_data
);

  logic [PIX_W-1:0] mem [0:(1 << ADDR_W) - 1];
  logic [PIX_W-1:0] rd_q_r;
  logic             byp_r;
  logic [PIX_W-1:0] byp_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered; hold data between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      byp_data_r <= wr_data;
    end
  end

  // Catch a read of the entry being written at the same edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_r <= 1'b0;
    end else if (rd_en) begin
      byp_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp_r ? byp_data_r : rd_q_r;

endmodule

FILE: rtl/fdr_box.sv
module fdr_box
  import fdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  box_upd_t upd,
  output box_res_t res
);

  logic              hist_r;
  logic [SIZE_W-1:0] sw_r, sh_r;
  logic              any_r, any_nxt;
  logic [COL_W-1:0]  min_x_r, max_x_r, min_x_nxt, max_x_nxt;
  logic [ROW_W-1:0]  min_y_r, max_y_r, min_y_nxt, max_y_nxt;

  // Grow the box by the current pixel
  always_comb begin
    any_nxt   = any_r | upd.diff;
    min_x_nxt = min_x_r;
    max_x_nxt = max_x_r;
    min_y_nxt = min_y_r;
    max_y_nxt = max_y_r;
    if (upd.diff) begin
      if (!any_r) begin
        min_x_nxt = upd.x;
        max_x_nxt = upd.x;
        min_y_nxt = upd.y;
        max_y_nxt = upd.y;
      end else begin
        if (upd.x < min_x_r) min_x_nxt = upd.x;
        if (upd.x > max_x_r) max_x_nxt = upd.x;
        if (upd.y < min_y_r) min_y_nxt = upd.y;
        if (upd.y > max_y_r) max_y_nxt = upd.y;
      end
    end
  end

  // Compose the frame result
  always_comb begin
    res = '0;
    if (!hist_r || (sw_r != upd.w) || (sh_r != upd.h)) begin
      res.changed     = 1'b1;
      res.full_frame  = 1'b1;
      res.rect_width  = upd.w;
      res.rect_height = upd.h;
    end else if (any_nxt) begin
      res.changed     = 1'b1;
      res.rect_x      = min_x_nxt;
      res.rect_y      = min_y_nxt;
      res.rect_width  = SIZE_W'({1'b0, max_x_nxt} - {1'b0, min_x_nxt} + 1'b1);
      res.rect_height = SIZE_W'({1'b0, max_y_nxt} - {1'b0, min_y_nxt} + 1'b1);
    end
  end

  // Advance the box; clear it and record the layout at frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r  <= 1'b0;
      sw_r    <= '0;
      sh_r    <= '0;
      any_r   <= 1'b0;
      min_x_r <= '0;
      max_x_r <= '0;
      min_y_r <= '0;
      max_y_r <= '0;
    end else if (upd.go) begin
      if (upd.last) begin
        hist_r  <= 1'b1;
        sw_r    <= upd.w;
        sh_r    <= upd.h;
        any_r   <= 1'b0;
        min_x_r <= '0;
        max_x_r <= '0;
        min_y_r <= '0;
        max_y_r <= '0;
      end else begin
        any_r   <= any_nxt;
        min_x_r <= min_x_nxt;
        max_x_r <= max_x_nxt;
        min_y_r <= min_y_nxt;
        max_y_r <= max_y_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  a_hist_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(hist_r) |-> $past(upd.go && upd.last))
    else $error("history became valid without a frame end");

  a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
    any_r |-> (min_x_r <= max_x_r) && (min_y_r <= max_y_r))
    else $error("box corners out of order");

  a_box_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !any_r |-> (min_x_r == '0) && (max_x_r == '0) && (min_y_r == '0) && (max_y_r == '0))
    else $error("box not clear while no difference seen");
`endif

endmodule
